### sv/lcg_pkg.sv
// lcg_pkg: shared constants, codes and types for the range-reduced lcg block
// no dependencies; compiled before the interfaces and modules
package lcg_pkg;

    localparam int XLEN  = 32;
    localparam int CNT_W = $clog2(XLEN);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(XLEN - 1);

    // generator presets
    localparam logic [XLEN-1:0] MUL_MSVC  = 32'd214013;
    localparam logic [XLEN-1:0] INC_MSVC  = 32'd2531011;
    localparam logic [XLEN-1:0] MUL_GLIBC = 32'd1103515245;
    localparam logic [XLEN-1:0] INC_GLIBC = 32'd12345;
    localparam logic [XLEN-1:0] MASK31    = 32'h7fff_ffff;

    // preset selector codes
    localparam logic [1:0] SEL_NONE    = 2'd0;
    localparam logic [1:0] SEL_MSVC    = 2'd1;
    localparam logic [1:0] SEL_GLIBC   = 2'd2;
    localparam logic [1:0] SEL_GLIBC31 = 2'd3;

    // action codes
    localparam logic [1:0] ACT_RAW    = 2'd0;
    localparam logic [1:0] ACT_LIMIT  = 2'd1;
    localparam logic [1:0] ACT_RANGE  = 2'd2;
    localparam logic [1:0] ACT_RESEED = 2'd3;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_ALG   = 2'd0;
    localparam logic [1:0] REG_LIMIT = 2'd1;
    localparam logic [1:0] REG_LOW   = 2'd2;
    localparam logic [1:0] REG_HIGH  = 2'd3;

    localparam int ADDR_W = 4;

    // work handed to the core when an item is accepted
    typedef struct packed {
        logic [1:0]      action;
        logic [XLEN-1:0] seed;
        logic [1:0]      sel;
        logic [XLEN-1:0] limit;
        logic [XLEN-1:0] low;
        logic [XLEN-1:0] width;
    } t_job;

    // core status back to the top level
    typedef struct packed {
        logic            idle;
        logic            done;
        logic [XLEN-1:0] value;
    } t_status;

endpackage

### sv/lcg_if.sv
// lcg_in_if / lcg_out_if: valid-ready channels for items and results
// depends on lcg_pkg
interface lcg_in_if import lcg_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [1:0]      action;
    logic [XLEN-1:0] seed_value;

    modport source (output valid, output action, output seed_value, input ready);
    modport sink   (input valid, input action, input seed_value, output ready);
endinterface

interface lcg_out_if import lcg_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [XLEN-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

### sv/lcg_core.sv
// lcg_core: generator state and sequencer around one shared 33-bit adder
// shift-add multiply, increment, compare, restoring remainder, offset; uses lcg_pkg
module lcg_core import lcg_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_job    i_job,
    input  logic    i_out_free,
    output t_status o_status
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_INC  = 7'b0000100,
        S_CHK  = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_OFS  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state           r_state, n_state;
    logic [XLEN-1:0]  r_gen, n_gen;
    logic [XLEN-1:0]  r_acc, n_acc;
    logic [XLEN-1:0]  r_mcand, n_mcand;
    logic [XLEN-1:0]  r_mplier, n_mplier;
    logic [XLEN-1:0]  r_rem, n_rem;
    logic [XLEN-1:0]  r_div, n_div;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [1:0]       r_action, n_action;
    logic [1:0]       r_sel, n_sel;
    logic [XLEN-1:0]  r_low, n_low;
    logic             r_wzero, n_wzero;

    logic [XLEN:0]    w_op_a;
    logic [XLEN:0]    w_op_b;
    logic             w_cin;
    logic [XLEN+1:0]  w_sum;
    logic             w_carry;
    logic [XLEN-1:0]  w_inc;
    logic [XLEN-1:0]  w_mul;
    logic [XLEN-1:0]  w_lim_eff;
    logic             w_done;

    // preset constants
    always_comb begin
        if (r_sel == SEL_GLIBC || r_sel == SEL_GLIBC31) begin
            w_inc = INC_GLIBC;
        end else begin
            w_inc = INC_MSVC;
        end
        if (i_job.sel == SEL_GLIBC || i_job.sel == SEL_GLIBC31) begin
            w_mul = MUL_GLIBC;
        end else begin
            w_mul = MUL_MSVC;
        end
        w_lim_eff = (i_job.limit == '0) ? XLEN'(1) : i_job.limit;
    end

    // shared adder operand selection
    always_comb begin
        w_op_a = '0;
        w_op_b = '0;
        w_cin  = 1'b0;
        unique case (r_state)
            S_MUL: begin
                w_op_a = {1'b0, r_acc};
                w_op_b = {1'b0, (r_mplier[0] ? r_mcand : '0)};
            end
            S_INC: begin
                w_op_a = {1'b0, r_acc};
                w_op_b = {1'b0, w_inc};
            end
            S_CHK: begin
                w_op_a = {1'b0, r_acc};
                w_op_b = ~{1'b0, r_div};
                w_cin  = 1'b1;
            end
            S_DIV: begin
                w_op_a = {r_rem, r_mplier[XLEN-1]};
                w_op_b = ~{1'b0, r_div};
                w_cin  = 1'b1;
            end
            S_OFS: begin
                w_op_a = {1'b0, r_acc};
                w_op_b = {1'b0, r_low};
            end
            default: begin
                w_op_a = '0;
            end
        endcase
        w_sum   = {1'b0, w_op_a} + {1'b0, w_op_b} + {{(XLEN+1){1'b0}}, w_cin};
        w_carry = w_sum[XLEN+1];
    end

    // sequencer and datapath next values
    always_comb begin
        n_state  = r_state;
        n_gen    = r_gen;
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_rem    = r_rem;
        n_div    = r_div;
        n_cnt    = r_cnt;
        n_action = r_action;
        n_sel    = r_sel;
        n_low    = r_low;
        n_wzero  = r_wzero;
        w_done   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_action = i_job.action;
                    n_sel    = i_job.sel;
                    n_low    = i_job.low;
                    n_wzero  = (i_job.width == '0);
                    n_div    = (i_job.action == ACT_LIMIT) ? w_lim_eff : i_job.width;
                    n_cnt    = '0;
                    if (i_job.action == ACT_RESEED) begin
                        n_acc   = i_job.seed;
                        n_state = S_DONE;
                    end else begin
                        n_acc    = '0;
                        n_mcand  = w_mul;
                        n_mplier = r_gen;
                        n_state  = S_MUL;
                    end
                end
            end
            // one multiplier bit per cycle, product kept mod 2^32
            S_MUL: begin
                n_acc    = w_sum[XLEN-1:0];
                n_mcand  = {r_mcand[XLEN-2:0], 1'b0};
                n_mplier = {1'b0, r_mplier[XLEN-1:1]};
                n_cnt    = r_cnt + CNT_W'(1);
                if (r_cnt == LAST_STEP) begin
                    n_state = S_INC;
                end
            end
            S_INC: begin
                if (r_sel == SEL_GLIBC31) begin
                    n_acc = w_sum[XLEN-1:0] & MASK31;
                end else begin
                    n_acc = w_sum[XLEN-1:0];
                end
                n_cnt = '0;
                priority if (r_action == ACT_LIMIT) begin
                    n_state = S_CHK;
                end else if (r_action == ACT_RANGE && r_wzero) begin
                    n_state = S_OFS;
                end else if (r_action == ACT_RANGE) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_DONE;
                end
                n_mplier = n_acc;
                n_rem    = '0;
            end
            // reduce only when the limit is strictly below the value
            S_CHK: begin
                n_mplier = r_acc;
                n_rem    = '0;
                n_cnt    = '0;
                if (w_carry && (r_acc != r_div)) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_DONE;
                end
            end
            // restoring remainder, one dividend bit per cycle
            S_DIV: begin
                n_rem    = w_carry ? w_sum[XLEN-1:0] : w_op_a[XLEN-1:0];
                n_mplier = {r_mplier[XLEN-2:0], 1'b0};
                n_cnt    = r_cnt + CNT_W'(1);
                if (r_cnt == LAST_STEP) begin
                    n_acc   = n_rem;
                    n_state = (r_action == ACT_RANGE) ? S_OFS : S_DONE;
                end
            end
            S_OFS: begin
                n_acc   = w_sum[XLEN-1:0];
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    w_done  = 1'b1;
                    n_gen   = r_acc;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_gen   <= '0;
        end else begin
            r_state <= n_state;
            r_gen   <= n_gen;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_rem    <= n_rem;
        r_div    <= n_div;
        r_cnt    <= n_cnt;
        r_action <= n_action;
        r_sel    <= n_sel;
        r_low    <= n_low;
        r_wzero  <= n_wzero;
    end

    assign o_status.idle  = (r_state == S_IDLE);
    assign o_status.done  = w_done;
    assign o_status.value = r_acc;

endmodule

### sv/lcg_random_with_range_reduction.sv
// From input transfer to result valid: a reseed loads the seed; a raw step runs multiply and
// increment; a limited step adds the compare, and the remainder when the value is reduced; a
// ranged step adds remainder and offset (only the offset for a full-width range).
// Throughput: one item at a time; the next input transfer is taken the cycle after a result
// is loaded. 32-step multiply and remainder use one adder; results wait in an output register.
// Synchronous active-low reset: generator value 0, preset 1, limit 1, range bounds 0.
// Depends on lcg_pkg, lcg_if (lcg_in_if, lcg_out_if) and lcg_core.
module lcg_random_with_range_reduction import lcg_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    lcg_in_if.sink             i_req,
    lcg_out_if.source          o_rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [XLEN-1:0]    pwdata,
    output logic [XLEN-1:0]    prdata,
    output logic               pready
);

    logic [1:0]      r_alg;
    logic [XLEN-1:0] r_limit;
    logic [XLEN-1:0] r_low;
    logic [XLEN-1:0] r_high;
    logic            r_out_valid;
    logic [XLEN-1:0] r_out_value;

    t_job            w_job;
    t_status         w_status;
    logic            w_start;
    logic            w_out_free;
    logic            w_wr;
    logic [1:0]      w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[3:2];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alg   <= SEL_MSVC;
            r_limit <= XLEN'(1);
            r_low   <= '0;
            r_high  <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_ALG:   r_alg   <= pwdata[1:0];
                REG_LIMIT: r_limit <= pwdata;
                REG_LOW:   r_low   <= pwdata;
                REG_HIGH:  r_high  <= pwdata;
                default:   r_alg   <= r_alg;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (w_idx)
            REG_ALG:   prdata = {{(XLEN-2){1'b0}}, r_alg};
            REG_LIMIT: prdata = r_limit;
            REG_LOW:   prdata = r_low;
            REG_HIGH:  prdata = r_high;
            default:   prdata = '0;
        endcase
    end

    // job for the core
    always_comb begin
        w_job.action = i_req.action;
        w_job.seed   = i_req.seed_value;
        w_job.sel    = r_alg;
        w_job.limit  = r_limit;
        w_job.low    = r_low;
        w_job.width  = r_high - r_low + XLEN'(1);
    end

    assign i_req.ready = w_status.idle;
    assign w_start     = i_req.valid & w_status.idle;
    assign w_out_free  = ~r_out_valid | o_rsp.ready;

    lcg_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_job      (w_job),
        .i_out_free (w_out_free),
        .o_status   (w_status)
    );

    // output register, refilled in the cycle its transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_status.done) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_status.done) begin
            r_out_value <= w_status.value;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.value = r_out_value;

endmodule
